// ===== rtl/spifcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spifcs_pkg
// Types and constants for the SPI NOR flash command sequencer: word layouts,
// command and action codes, flash opcodes and the one-hot phase encoding.
// ----------------------------------------------------------------------------
package spifcs_pkg;

    // Input word: one serial tick, a command start or a program data byte
    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  command;
        logic [23:0] address;
        logic [23:0] count;
        logic [7:0]  write_byte;
        logic        miso;
    } t_in_word;

    // Result word: serial lines and status after the word has been applied
    typedef struct packed {
        logic        cs_n;
        logic        sclk;
        logic        mosi;
        logic        read_valid;
        logic [7:0]  read_byte;
        logic        need_byte;
        logic        busy_res;
        logic        done_res;
        logic        timed_out;
        logic [7:0]  maker_id;
        logic [15:0] part_id;
    } t_out_word;

    // Action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_DATA  = 2'd2;

    // Command codes
    localparam logic [2:0] CMD_READ_ID      = 3'd0;
    localparam logic [2:0] CMD_SECTOR_ERASE = 3'd1;
    localparam logic [2:0] CMD_BLOCK_ERASE  = 3'd2;
    localparam logic [2:0] CMD_CHIP_ERASE   = 3'd3;
    localparam logic [2:0] CMD_PROGRAM      = 3'd4;
    localparam logic [2:0] CMD_READ         = 3'd5;

    // Flash opcodes
    localparam logic [7:0] OP_WREN        = 8'h06;
    localparam logic [7:0] OP_READ_STATUS = 8'h05;
    localparam logic [7:0] OP_READ_ID     = 8'h9F;
    localparam logic [7:0] OP_SECTOR_ERS  = 8'h20;
    localparam logic [7:0] OP_BLOCK_ERS   = 8'hD8;
    localparam logic [7:0] OP_CHIP_ERS    = 8'hC7;
    localparam logic [7:0] OP_PAGE_PROG   = 8'h02;
    localparam logic [7:0] OP_READ_DATA   = 8'h03;
    localparam logic [7:0] DUMMY_BYTE     = 8'hFF;

    // Configuration register indexes and reset values
    localparam logic       CFG_POLL_LIMIT = 1'b0;
    localparam logic       CFG_POLL_GAP   = 1'b1;
    localparam logic [19:0] POLL_LIMIT_RST = 20'd500000;
    localparam logic [19:0] POLL_GAP_RST   = 20'd1000;

    // Sequencer phases, one-hot
    typedef enum logic [12:0] {
        PH_IDLE      = 13'b0000000000001,
        PH_POLL_OP   = 13'b0000000000010,
        PH_POLL_RD   = 13'b0000000000100,
        PH_POLL_WAIT = 13'b0000000001000,
        PH_DESEL1    = 13'b0000000010000,
        PH_WREN      = 13'b0000000100000,
        PH_DESEL2    = 13'b0000001000000,
        PH_OPCODE    = 13'b0000010000000,
        PH_ADDR_H    = 13'b0000100000000,
        PH_ADDR_M    = 13'b0001000000000,
        PH_ADDR_L    = 13'b0010000000000,
        PH_DATA      = 13'b0100000000000,
        PH_NEED      = 13'b1000000000000
    } t_phase;

    // Opcode of each command
    function automatic logic [7:0] cmd_opcode(input logic [2:0] cmd);
        logic [7:0] op;
        unique case (cmd)
            CMD_READ_ID:      op = OP_READ_ID;
            CMD_SECTOR_ERASE: op = OP_SECTOR_ERS;
            CMD_BLOCK_ERASE:  op = OP_BLOCK_ERS;
            CMD_CHIP_ERASE:   op = OP_CHIP_ERS;
            CMD_PROGRAM:      op = OP_PAGE_PROG;
            CMD_READ:         op = OP_READ_DATA;
            default:          op = OP_READ_ID;
        endcase
        return op;
    endfunction

    // Phases that shift a byte on the bus
    function automatic logic is_byte_phase(input t_phase ph);
        return (ph == PH_POLL_OP) || (ph == PH_POLL_RD) || (ph == PH_WREN) ||
               (ph == PH_OPCODE) || (ph == PH_ADDR_H) || (ph == PH_ADDR_M) ||
               (ph == PH_ADDR_L) || (ph == PH_DATA);
    endfunction

endpackage

// ===== rtl/spi_flash_command_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_flash_command_sequencer
// Mode-0 SPI master that runs serial NOR flash commands (read id, erases,
// program, read), each opened by a busy poll and, for writes, write enable.
// ----------------------------------------------------------------------------
// Each input word is one step of the sequencer: a serial tick, a command
// start or a program data byte. One word is taken per clock cycle unless the
// output stalls; its result word (serial lines, status, received byte) is
// loaded into the output register at the same edge and shown the cycle after.
// Input ready falls only while the output register holds a word that is not
// taken. A bit on the SPI bus takes two tick words (clock high, then low).
// Configuration writes are always accepted; they belong only to idle periods,
// which the user must keep to, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module spi_flash_command_sequencer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  spifcs_pkg::t_in_word  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output spifcs_pkg::t_out_word o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [19:0]           i_cfg_data
);
    import spifcs_pkg::*;

    // Sequencer state
    t_phase      r_phase,        n_phase;
    logic [2:0]  r_cur_cmd,      n_cur_cmd;
    logic [23:0] r_addr_hold,    n_addr_hold;
    logic [23:0] r_bytes_left,   n_bytes_left;
    logic [3:0]  r_bit_index,    n_bit_index;
    logic        r_clock_high,   n_clock_high;
    logic [7:0]  r_shift_out,    n_shift_out;
    logic [7:0]  r_shift_in,     n_shift_in;
    logic [19:0] r_poll_count,   n_poll_count;
    logic [19:0] r_gap_count,    n_gap_count;
    logic [8:0]  r_pending,      n_pending;
    logic [23:0] r_id_store,     n_id_store;
    logic        r_timed_out,    n_timed_out;
    logic [19:0] r_poll_limit;
    logic [19:0] r_poll_gap;

    // Output register
    logic        r_out_valid;
    t_out_word   r_out_data;
    t_out_word   w_result;

    // Step control
    logic        w_accept;
    logic        w_load;
    t_phase      w_load_phase;
    logic [7:0]  w_load_val;
    logic        w_finish;
    logic        w_next_data;
    logic        w_rd_valid;
    logic [7:0]  w_rd_byte;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Next state for the accepted word
    always_comb begin
        n_phase      = r_phase;
        n_cur_cmd    = r_cur_cmd;
        n_addr_hold  = r_addr_hold;
        n_bytes_left = r_bytes_left;
        n_bit_index  = r_bit_index;
        n_clock_high = r_clock_high;
        n_shift_out  = r_shift_out;
        n_shift_in   = r_shift_in;
        n_poll_count = r_poll_count;
        n_gap_count  = r_gap_count;
        n_pending    = r_pending;
        n_id_store   = r_id_store;
        n_timed_out  = r_timed_out;
        w_load       = 1'b0;
        w_load_phase = PH_IDLE;
        w_load_val   = '0;
        w_finish     = 1'b0;
        w_next_data  = 1'b0;
        w_rd_valid   = 1'b0;
        w_rd_byte    = '0;

        unique case (i_in_data.action)
            ACT_TICK: begin
                if (is_byte_phase(r_phase)) begin
                    if (!r_clock_high) begin
                        // rising edge: sample MISO
                        n_clock_high = 1'b1;
                        if (i_in_data.miso) begin
                            n_shift_in[~r_bit_index[2:0]] = 1'b1;
                        end
                    end else begin
                        // falling edge: next bit, or the byte is complete
                        n_clock_high = 1'b0;
                        n_bit_index  = r_bit_index + 4'd1;
                        if (n_bit_index[3]) begin
                            unique case (r_phase)
                                PH_POLL_OP: begin
                                    w_load       = 1'b1;
                                    w_load_phase = PH_POLL_RD;
                                    w_load_val   = DUMMY_BYTE;
                                end
                                PH_POLL_RD: begin
                                    if (!r_shift_in[0]) begin
                                        n_phase = PH_DESEL1;
                                    end else begin
                                        n_poll_count = r_poll_count + 20'd1;
                                        if (n_poll_count >= r_poll_limit) begin
                                            n_timed_out = 1'b1;
                                            n_phase     = PH_DESEL1;
                                        end else if (r_poll_gap == '0) begin
                                            w_load       = 1'b1;
                                            w_load_phase = PH_POLL_RD;
                                            w_load_val   = DUMMY_BYTE;
                                        end else begin
                                            n_gap_count = r_poll_gap;
                                            n_phase     = PH_POLL_WAIT;
                                        end
                                    end
                                end
                                PH_WREN: n_phase = PH_DESEL2;
                                PH_OPCODE: begin
                                    if (r_cur_cmd == CMD_CHIP_ERASE) begin
                                        w_finish = 1'b1;
                                    end else if (r_cur_cmd == CMD_READ_ID) begin
                                        w_next_data = 1'b1;
                                    end else begin
                                        w_load       = 1'b1;
                                        w_load_phase = PH_ADDR_H;
                                        w_load_val   = r_addr_hold[23:16];
                                    end
                                end
                                PH_ADDR_H: begin
                                    w_load       = 1'b1;
                                    w_load_phase = PH_ADDR_M;
                                    w_load_val   = r_addr_hold[15:8];
                                end
                                PH_ADDR_M: begin
                                    w_load       = 1'b1;
                                    w_load_phase = PH_ADDR_L;
                                    w_load_val   = r_addr_hold[7:0];
                                end
                                PH_ADDR_L: begin
                                    if (r_cur_cmd == CMD_SECTOR_ERASE ||
                                        r_cur_cmd == CMD_BLOCK_ERASE ||
                                        r_bytes_left == '0) begin
                                        w_finish = 1'b1;
                                    end else begin
                                        w_next_data = 1'b1;
                                    end
                                end
                                PH_DATA: begin
                                    // id bytes land high byte first
                                    if (r_cur_cmd == CMD_READ_ID) begin
                                        if (r_bytes_left == 24'd3) begin
                                            n_id_store[23:16] = r_shift_in;
                                        end else if (r_bytes_left == 24'd2) begin
                                            n_id_store[15:8] = r_shift_in;
                                        end else begin
                                            n_id_store[7:0] = r_shift_in;
                                        end
                                    end else if (r_cur_cmd == CMD_READ) begin
                                        w_rd_valid = 1'b1;
                                        w_rd_byte  = r_shift_in;
                                    end
                                    n_bytes_left = r_bytes_left - 24'd1;
                                    if (n_bytes_left == '0) begin
                                        w_finish = 1'b1;
                                    end else begin
                                        w_next_data = 1'b1;
                                    end
                                end
                                default: w_finish = 1'b1;
                            endcase
                        end
                    end
                end else begin
                    unique case (r_phase)
                        PH_IDLE, PH_NEED: begin
                        end
                        PH_POLL_WAIT: begin
                            n_gap_count = r_gap_count - 20'd1;
                            if (n_gap_count == '0) begin
                                w_load       = 1'b1;
                                w_load_phase = PH_POLL_RD;
                                w_load_val   = DUMMY_BYTE;
                            end
                        end
                        PH_DESEL1: begin
                            w_load = 1'b1;
                            if (r_cur_cmd == CMD_SECTOR_ERASE || r_cur_cmd == CMD_BLOCK_ERASE ||
                                r_cur_cmd == CMD_CHIP_ERASE || r_cur_cmd == CMD_PROGRAM) begin
                                w_load_phase = PH_WREN;
                                w_load_val   = OP_WREN;
                            end else begin
                                w_load_phase = PH_OPCODE;
                                w_load_val   = cmd_opcode(r_cur_cmd);
                            end
                        end
                        PH_DESEL2: begin
                            w_load       = 1'b1;
                            w_load_phase = PH_OPCODE;
                            w_load_val   = cmd_opcode(r_cur_cmd);
                        end
                        default: begin
                            n_phase      = PH_IDLE;
                            n_clock_high = 1'b0;
                            n_bit_index  = '0;
                        end
                    endcase
                end
            end
            ACT_START: begin
                if (r_phase == PH_IDLE && i_in_data.command <= CMD_READ) begin
                    n_cur_cmd    = i_in_data.command;
                    n_addr_hold  = i_in_data.address;
                    n_bytes_left = (i_in_data.command == CMD_READ_ID) ? 24'd3
                                                                      : i_in_data.count;
                    n_poll_count = '0;
                    n_gap_count  = '0;
                    n_pending    = '0;
                    n_timed_out  = 1'b0;
                    w_load       = 1'b1;
                    w_load_phase = PH_POLL_OP;
                    w_load_val   = OP_READ_STATUS;
                end
            end
            ACT_DATA: begin
                if (r_phase == PH_NEED) begin
                    w_load       = 1'b1;
                    w_load_phase = PH_DATA;
                    w_load_val   = i_in_data.write_byte;
                end else if (r_phase != PH_IDLE && r_cur_cmd == CMD_PROGRAM) begin
                    n_pending = {1'b1, i_in_data.write_byte};
                end
            end
            default: begin
            end
        endcase

        // Next data byte: held program byte, wait for the host, or dummy
        if (w_next_data) begin
            if (r_cur_cmd == CMD_PROGRAM) begin
                if (r_pending[8]) begin
                    w_load       = 1'b1;
                    w_load_phase = PH_DATA;
                    w_load_val   = r_pending[7:0];
                    n_pending    = '0;
                end else begin
                    n_phase      = PH_NEED;
                    n_clock_high = 1'b0;
                end
            end else begin
                w_load       = 1'b1;
                w_load_phase = PH_DATA;
                w_load_val   = DUMMY_BYTE;
            end
        end

        // End of command
        if (w_finish) begin
            n_phase      = PH_IDLE;
            n_clock_high = 1'b0;
            n_bit_index  = '0;
        end

        // Start shifting a new byte
        if (w_load) begin
            n_phase      = w_load_phase;
            n_shift_out  = w_load_val;
            n_shift_in   = '0;
            n_bit_index  = '0;
            n_clock_high = 1'b0;
        end
    end

    // Result word from the updated state
    always_comb begin
        w_result.cs_n       = (n_phase == PH_IDLE) || (n_phase == PH_DESEL1) ||
                              (n_phase == PH_DESEL2);
        w_result.sclk       = n_clock_high;
        w_result.mosi       = is_byte_phase(n_phase) ? n_shift_out[~n_bit_index[2:0]] : 1'b0;
        w_result.read_valid = w_rd_valid;
        w_result.read_byte  = w_rd_byte;
        w_result.need_byte  = (n_phase == PH_NEED);
        w_result.busy_res   = (n_phase != PH_IDLE);
        w_result.done_res   = w_finish;
        w_result.timed_out  = n_timed_out;
        w_result.maker_id   = n_id_store[23:16];
        w_result.part_id    = n_id_store[15:0];
    end

    // State, configuration and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_cur_cmd    <= '0;
            r_addr_hold  <= '0;
            r_bytes_left <= '0;
            r_bit_index  <= '0;
            r_clock_high <= 1'b0;
            r_shift_out  <= '0;
            r_shift_in   <= '0;
            r_poll_count <= '0;
            r_gap_count  <= '0;
            r_pending    <= '0;
            r_id_store   <= '0;
            r_timed_out  <= 1'b0;
            r_poll_limit <= POLL_LIMIT_RST;
            r_poll_gap   <= POLL_GAP_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase      <= n_phase;
                r_cur_cmd    <= n_cur_cmd;
                r_addr_hold  <= n_addr_hold;
                r_bytes_left <= n_bytes_left;
                r_bit_index  <= n_bit_index;
                r_clock_high <= n_clock_high;
                r_shift_out  <= n_shift_out;
                r_shift_in   <= n_shift_in;
                r_poll_count <= n_poll_count;
                r_gap_count  <= n_gap_count;
                r_pending    <= n_pending;
                r_id_store   <= n_id_store;
                r_timed_out  <= n_timed_out;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_POLL_LIMIT) begin
                    r_poll_limit <= i_cfg_data;
                end else begin
                    r_poll_gap <= i_cfg_data;
                end
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= w_result;
        end
    end

endmodule

// ===== rtl/spifcs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spifcs_checker
// Port-level checks for the SPI flash command sequencer, bound to the top.
// ----------------------------------------------------------------------------
module spifcs_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input spifcs_pkg::t_out_word o_out_data
);
    import spifcs_pkg::*;

    // Output word held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word dropped or changed while stalled");

    // Every accepted input word yields a result word
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted word produced no result");

    // Command end always shows chip select released and clock low
    a_done_desel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |->
            o_out_data.cs_n && !o_out_data.sclk && !o_out_data.busy_res)
        else $error("done reported with bus active");

    // Waiting for a program byte keeps the bus selected and the clock low
    a_need_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.need_byte |->
            !o_out_data.cs_n && !o_out_data.sclk && o_out_data.busy_res)
        else $error("program byte wait with bus in wrong state");

    // No result word straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind spi_flash_command_sequencer spifcs_checker u_spifcs_checker (.*);
